@@ sv/ssi_pkg.sv @@
// Shared types and constants for the segment intersection core.
package ssi_pkg;

    localparam int THRESH_W = 30;

    // Control word that rides alongside the divider data from cell to cell.
    typedef struct packed {
        logic valid;
        logic par;      // determinant at or below threshold
        logic ovf_x;    // |Nx| >= |d| * 2^QB, quotient far out of range
        logic ovf_y;
        logic neg_x;    // quotient sign
        logic neg_y;
    } t_cell_ctl;

endpackage

@@ sv/segment_segment_intersection_core.sv @@
// One word per cycle, except while a finished word sits unclaimed at the output (o_stall).
// Six front stages form the determinant, the numerators and their magnitudes;
// a row of COORD_WIDTH+1 divider cells yields one quotient bit each; two back
// stages restore the sign and run the extent check into the output register.
// Reset (synchronous, i_rst_n low) empties the pipe and clears the threshold.
module segment_segment_intersection_core #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic        [ssi_pkg::THRESH_W-1:0] i_cfg_wdata,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [COORD_WIDTH-1:0]      i_seg_a_start_x,
    input  logic signed [COORD_WIDTH-1:0]      i_seg_a_start_y,
    input  logic signed [COORD_WIDTH-1:0]      i_seg_a_end_x,
    input  logic signed [COORD_WIDTH-1:0]      i_seg_a_end_y,
    input  logic signed [COORD_WIDTH-1:0]      i_seg_b_start_x,
    input  logic signed [COORD_WIDTH-1:0]      i_seg_b_start_y,
    input  logic signed [COORD_WIDTH-1:0]      i_seg_b_end_x,
    input  logic signed [COORD_WIDTH-1:0]      i_seg_b_end_y,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_hit,
    output logic signed [COORD_WIDTH-1:0]      o_cross_x,
    output logic signed [COORD_WIDTH-1:0]      o_cross_y
);
    localparam int W  = COORD_WIDTH;
    localparam int NW = 3*W + 3;
    localparam int DW = 2*W + 3;
    localparam int QB = W + 1;
    localparam int SW = QB + 1;   // signed quotient width

    logic [ssi_pkg::THRESH_W-1:0] r_thr;
    logic en;

    // whole pipe moves together; it only holds when a finished word sits unclaimed
    assign en      = !o_valid || !i_stall;
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    ssi_pkg::t_cell_ctl c_ctl [QB+1];
    logic [NW-1:0]  c_rx  [QB+1];
    logic [NW-1:0]  c_ry  [QB+1];
    logic [DW-1:0]  c_den [QB+1];
    logic [QB-1:0]  c_qx  [QB+1];
    logic [QB-1:0]  c_qy  [QB+1];
    logic [8*W-1:0] c_pts [QB+1];

    ssi_front #(.W(W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_thr   (r_thr),
        .i_ax1   (i_seg_a_start_x),
        .i_ay1   (i_seg_a_start_y),
        .i_ax2   (i_seg_a_end_x),
        .i_ay2   (i_seg_a_end_y),
        .i_bx1   (i_seg_b_start_x),
        .i_by1   (i_seg_b_start_y),
        .i_bx2   (i_seg_b_end_x),
        .i_by2   (i_seg_b_end_y),
        .o_ctl   (c_ctl[0]),
        .o_rem_x (c_rx[0]),
        .o_rem_y (c_ry[0]),
        .o_den   (c_den[0]),
        .o_pts   (c_pts[0])
    );

    assign c_qx[0] = '0;
    assign c_qy[0] = '0;

    // divider row: cell k resolves quotient bit QB-1-k
    for (genvar k = 0; k < QB; k++) begin : g_cell
        ssi_div_cell #(.W(W), .BIT(QB-1-k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (c_ctl[k]),
            .i_rem_x (c_rx[k]),
            .i_rem_y (c_ry[k]),
            .i_den   (c_den[k]),
            .i_qx    (c_qx[k]),
            .i_qy    (c_qy[k]),
            .i_pts   (c_pts[k]),
            .o_ctl   (c_ctl[k+1]),
            .o_rem_x (c_rx[k+1]),
            .o_rem_y (c_ry[k+1]),
            .o_den   (c_den[k+1]),
            .o_qx    (c_qx[k+1]),
            .o_qy    (c_qy[k+1]),
            .o_pts   (c_pts[k+1])
        );
    end

    // back stage 1: apply quotient sign
    logic                 r_sv, r_skip;
    logic signed [SW-1:0] r_sqx, r_sqy;
    logic [8*W-1:0]       r_spts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else if (en) begin
            r_sv <= c_ctl[QB].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_skip <= c_ctl[QB].par || c_ctl[QB].ovf_x || c_ctl[QB].ovf_y;
            r_sqx  <= c_ctl[QB].neg_x ? -SW'(c_qx[QB]) : SW'(c_qx[QB]);
            r_sqy  <= c_ctl[QB].neg_y ? -SW'(c_qy[QB]) : SW'(c_qy[QB]);
            r_spts <= c_pts[QB];
        end
    end

    // back stage 2: extent check, bounds included
    function automatic logic f_within(logic signed [SW-1:0] q,
                                      logic signed [W-1:0] e1,
                                      logic signed [W-1:0] e2);
        logic signed [SW-1:0] a, b;
        a = SW'(e1);
        b = SW'(e2);
        return (q >= a && q <= b) || (q >= b && q <= a);
    endfunction

    logic signed [W-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    logic n_hit;

    always_comb begin
        ax1   = r_spts[7*W +: W];
        ay1   = r_spts[6*W +: W];
        ax2   = r_spts[5*W +: W];
        ay2   = r_spts[4*W +: W];
        bx1   = r_spts[3*W +: W];
        by1   = r_spts[2*W +: W];
        bx2   = r_spts[1*W +: W];
        by2   = r_spts[0 +: W];
        n_hit = !r_skip
             && f_within(r_sqx, ax1, ax2) && f_within(r_sqx, bx1, bx2)
             && f_within(r_sqy, ay1, ay2) && f_within(r_sqy, by1, by2);
    end

    logic r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_hit     <= n_hit;
            o_cross_x <= n_hit ? r_sqx[W-1:0] : '0;
            o_cross_y <= n_hit ? r_sqy[W-1:0] : '0;
        end
    end

    assign o_valid = r_ov;

endmodule

@@ sv/ssi_front.sv @@
// Front pipeline: determinant, numerators, magnitudes and range flags.
module ssi_front #(
    parameter int W = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic        [ssi_pkg::THRESH_W-1:0] i_thr,
    input  logic signed [W-1:0]               i_ax1,
    input  logic signed [W-1:0]               i_ay1,
    input  logic signed [W-1:0]               i_ax2,
    input  logic signed [W-1:0]               i_ay2,
    input  logic signed [W-1:0]               i_bx1,
    input  logic signed [W-1:0]               i_by1,
    input  logic signed [W-1:0]               i_bx2,
    input  logic signed [W-1:0]               i_by2,
    output ssi_pkg::t_cell_ctl                o_ctl,
    output logic        [3*W+2:0]             o_rem_x,
    output logic        [3*W+2:0]             o_rem_y,
    output logic        [2*W+2:0]             o_den,
    output logic        [8*W-1:0]             o_pts
);
    localparam int NW = 3*W + 3;
    localparam int DW = 2*W + 3;
    localparam int QB = W + 1;
    localparam int CW = (DW > ssi_pkg::THRESH_W) ? DW : ssi_pkg::THRESH_W;

    logic [5:0] r_v;
    logic [8*W-1:0] r_pts1, r_pts2, r_pts3, r_pts4, r_pts5, r_pts6;

    // stage 1
    logic signed [W:0]     r_dax1, r_day1, r_dbx1, r_dby1;
    logic signed [2*W-1:0] r_pa1, r_pa2, r_pb1, r_pb2;
    // stage 2
    logic signed [W:0]     r_dax2, r_day2, r_dbx2, r_dby2;
    logic signed [2*W+1:0] r_dd1, r_dd2;
    logic signed [2*W:0]   r_pa, r_pb;
    // stage 3
    logic signed [DW-1:0]  r_d3;
    logic signed [3*W+1:0] r_nx1, r_nx2, r_ny1, r_ny2;
    // stage 4
    logic signed [DW-1:0]  r_d4;
    logic signed [NW-1:0]  r_nx, r_ny;
    // stage 5
    logic [NW-1:0] r_mx, r_my;
    logic [DW-1:0] r_md;
    logic          r_sx, r_sy;
    // stage 6
    ssi_pkg::t_cell_ctl r_ctl;
    logic [NW-1:0] r_rx, r_ry;
    logic [DW-1:0] r_den;

    logic signed [W:0] n_dax, n_day, n_dbx, n_dby;
    logic [CW-1:0]     n_md_ext, n_thr_ext;
    logic [NW+QB-1:0]  n_dsh;

    always_comb begin
        n_dax     = {i_ax1[W-1], i_ax1} - {i_ax2[W-1], i_ax2};
        n_day     = {i_ay1[W-1], i_ay1} - {i_ay2[W-1], i_ay2};
        n_dbx     = {i_bx1[W-1], i_bx1} - {i_bx2[W-1], i_bx2};
        n_dby     = {i_by1[W-1], i_by1} - {i_by2[W-1], i_by2};
        n_md_ext  = CW'(r_md);
        n_thr_ext = CW'(i_thr);
        n_dsh     = {{(NW-DW){1'b0}}, r_md, {QB{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pts1 <= {i_ax1, i_ay1, i_ax2, i_ay2, i_bx1, i_by1, i_bx2, i_by2};
            r_dax1 <= n_dax;
            r_day1 <= n_day;
            r_dbx1 <= n_dbx;
            r_dby1 <= n_dby;
            r_pa1  <= i_ax1 * i_ay2;
            r_pa2  <= i_ay1 * i_ax2;
            r_pb1  <= i_bx1 * i_by2;
            r_pb2  <= i_by1 * i_bx2;

            r_pts2 <= r_pts1;
            r_dax2 <= r_dax1;
            r_day2 <= r_day1;
            r_dbx2 <= r_dbx1;
            r_dby2 <= r_dby1;
            r_dd1  <= r_dax1 * r_dby1;
            r_dd2  <= r_day1 * r_dbx1;
            r_pa   <= r_pa1 - r_pa2;
            r_pb   <= r_pb1 - r_pb2;

            r_pts3 <= r_pts2;
            r_d3   <= r_dd1 - r_dd2;
            r_nx1  <= r_pa * r_dbx2;
            r_nx2  <= r_dax2 * r_pb;
            r_ny1  <= r_pa * r_dby2;
            r_ny2  <= r_day2 * r_pb;

            r_pts4 <= r_pts3;
            r_d4   <= r_d3;
            r_nx   <= r_nx1 - r_nx2;
            r_ny   <= r_ny1 - r_ny2;

            r_pts5 <= r_pts4;
            r_mx   <= r_nx[NW-1] ? NW'(-r_nx) : NW'(r_nx);
            r_my   <= r_ny[NW-1] ? NW'(-r_ny) : NW'(r_ny);
            r_md   <= r_d4[DW-1] ? DW'(-r_d4) : DW'(r_d4);
            r_sx   <= r_nx[NW-1] ^ r_d4[DW-1];
            r_sy   <= r_ny[NW-1] ^ r_d4[DW-1];

            r_pts6 <= r_pts5;
            r_rx   <= r_mx;
            r_ry   <= r_my;
            r_den  <= r_md;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= r_v[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl.par   <= (n_md_ext <= n_thr_ext);
            r_ctl.ovf_x <= ({{QB{1'b0}}, r_mx} >= n_dsh);
            r_ctl.ovf_y <= ({{QB{1'b0}}, r_my} >= n_dsh);
            r_ctl.neg_x <= r_sx;
            r_ctl.neg_y <= r_sy;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_rem_x = r_rx;
    assign o_rem_y = r_ry;
    assign o_den   = r_den;
    assign o_pts   = r_pts6;

endmodule

@@ sv/ssi_div_cell.sv @@
// One divider cell: resolves one quotient bit for both the x and y lanes.
module ssi_div_cell #(
    parameter int W   = 16,
    parameter int BIT = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  ssi_pkg::t_cell_ctl i_ctl,
    input  logic [3*W+2:0]     i_rem_x,
    input  logic [3*W+2:0]     i_rem_y,
    input  logic [2*W+2:0]     i_den,
    input  logic [W:0]         i_qx,
    input  logic [W:0]         i_qy,
    input  logic [8*W-1:0]     i_pts,
    output ssi_pkg::t_cell_ctl o_ctl,
    output logic [3*W+2:0]     o_rem_x,
    output logic [3*W+2:0]     o_rem_y,
    output logic [2*W+2:0]     o_den,
    output logic [W:0]         o_qx,
    output logic [W:0]         o_qy,
    output logic [8*W-1:0]     o_pts
);
    localparam int NW = 3*W + 3;
    localparam int DW = 2*W + 3;
    localparam int QB = W + 1;
    localparam int XW = NW + QB;

    ssi_pkg::t_cell_ctl r_ctl;
    logic [NW-1:0] r_rx, r_ry;
    logic [DW-1:0] r_den;
    logic [QB-1:0] r_qx, r_qy;
    logic [8*W-1:0] r_pts;

    logic [XW-1:0] n_dsh, n_rx_ext, n_ry_ext, n_dx, n_dy;
    logic          n_gx, n_gy;

    always_comb begin
        n_dsh    = XW'(i_den) << BIT;
        n_rx_ext = XW'(i_rem_x);
        n_ry_ext = XW'(i_rem_y);
        n_dx     = n_rx_ext - n_dsh;
        n_dy     = n_ry_ext - n_dsh;
        n_gx     = (n_rx_ext >= n_dsh);
        n_gy     = (n_ry_ext >= n_dsh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl.par   <= i_ctl.par;
            r_ctl.ovf_x <= i_ctl.ovf_x;
            r_ctl.ovf_y <= i_ctl.ovf_y;
            r_ctl.neg_x <= i_ctl.neg_x;
            r_ctl.neg_y <= i_ctl.neg_y;
            r_rx        <= n_gx ? n_dx[NW-1:0] : i_rem_x;
            r_ry        <= n_gy ? n_dy[NW-1:0] : i_rem_y;
            r_den       <= i_den;
            r_qx        <= i_qx | (QB'(n_gx) << BIT);
            r_qy        <= i_qy | (QB'(n_gy) << BIT);
            r_pts       <= i_pts;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_rem_x = r_rx;
    assign o_rem_y = r_ry;
    assign o_den   = r_den;
    assign o_qx    = r_qx;
    assign o_qy    = r_qy;
    assign o_pts   = r_pts;

endmodule
